// ----- design/b64e_pkg.sv -----
package b64e_pkg;

   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned MAX_CHARS  = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic VARIANT_URL = 1'b0;
   localparam logic VARIANT_STD = 1'b1;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // one accepted byte, turned into its run of output characters
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [2:0]                count;
      logic                      last;
   } entry_type;

   function automatic logic [7:0] enc_char(input logic [5:0] six, input logic variant);
      logic [7:0] wide;
      wide = {2'b00, six};
      if (six < 6'd26) begin
         enc_char = wide + 8'd65;
      end else if (six < 6'd52) begin
         enc_char = wide + 8'd71;
      end else if (six < 6'd62) begin
         enc_char = wide - 8'd4;
      end else if (six == 6'd62) begin
         enc_char = (variant == VARIANT_STD) ? 8'h2B : 8'h2D;
      end else begin
         enc_char = (variant == VARIANT_STD) ? 8'h2F : 8'h5F;
      end
   endfunction

endpackage

// ----- design/b64e_front.sv -----
module b64e_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 variant,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  logic                 fifo_full,
   output logic                 push,
   output b64e_pkg::entry_type  push_data
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          carry_ff, carry_in;
   logic                accept;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   assign push      = accept;

   always_comb begin
      phase_in  = phase_ff;
      carry_in  = carry_ff;
      push_data = '0;
      push_data.last = req_in_last;
      case (phase_ff)
         b64e_pkg::PHASE_SECOND: begin
            push_data.chars[0] = b64e_pkg::enc_char({carry_ff[1:0], req_in_byte[7:4]}, variant);
            push_data.count    = 3'd1;
            if (req_in_last) begin
               push_data.chars[1] = b64e_pkg::enc_char({req_in_byte[3:0], 2'b00}, variant);
               push_data.chars[2] = b64e_pkg::PAD_CHAR;
               push_data.count    = (variant == b64e_pkg::VARIANT_STD) ? 3'd3 : 3'd2;
            end
            carry_in = req_in_byte[3:0];
            phase_in = b64e_pkg::PHASE_THIRD;
         end
         b64e_pkg::PHASE_THIRD: begin
            push_data.chars[0] = b64e_pkg::enc_char({carry_ff, req_in_byte[7:6]}, variant);
            push_data.chars[1] = b64e_pkg::enc_char(req_in_byte[5:0], variant);
            push_data.count    = 3'd2;
            carry_in = 4'd0;
            phase_in = b64e_pkg::PHASE_FIRST;
         end
         default: begin
            // unused phase code behaves like the start of a group
            push_data.chars[0] = b64e_pkg::enc_char(req_in_byte[7:2], variant);
            push_data.count    = 3'd1;
            if (req_in_last) begin
               push_data.chars[1] = b64e_pkg::enc_char({req_in_byte[1:0], 4'b0000}, variant);
               push_data.chars[2] = b64e_pkg::PAD_CHAR;
               push_data.chars[3] = b64e_pkg::PAD_CHAR;
               push_data.count    = (variant == b64e_pkg::VARIANT_STD) ? 3'd4 : 3'd2;
            end
            carry_in = {2'b00, req_in_byte[1:0]};
            phase_in = b64e_pkg::PHASE_SECOND;
         end
      endcase
      if (req_in_last) begin
         phase_in = b64e_pkg::PHASE_FIRST;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_FIRST;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ----- design/b64e_fifo.sv -----
module b64e_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64e_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output b64e_pkg::entry_type  pop_data,
   output logic                 empty
);

   b64e_pkg::entry_type                   store_ff [b64e_pkg::FIFO_DEPTH];
   logic [b64e_pkg::PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::CNT_W-1:0]            count_ff, count_in;
   logic                                  do_push, do_pop;

   assign full     = (count_ff == b64e_pkg::CNT_W'(b64e_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64e_pkg::PTR_W'(b64e_pkg::FIFO_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64e_pkg::PTR_W'(b64e_pkg::FIFO_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/b64e_back.sv -----
module b64e_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fifo_empty,
   input  b64e_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, final_char;

   // output register frees up when empty or when its transaction completes
   assign load       = !fifo_empty && (!valid_ff || !rsp_stall);
   assign final_char = ({1'b0, idx_ff} == (head.count - 3'd1));
   assign pop        = load && final_char;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         char_in  = head.chars[idx_ff];
         last_in  = head.last && final_char;
         idx_in   = final_char ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

endmodule

// ----- design/base64_stream_encoder.sv -----
// Streaming base64 encoder: one raw byte per request transaction, one ASCII
// character per response transaction, the final character of a message
// flagged by rsp_out_last. The csr bit picks the URL-safe alphabet with no
// padding (0, reset value) or the standard alphabet with '=' padding (1);
// write it only while no transaction is in flight. It applies to every byte
// accepted after the write, in the middle of a message too. The front end
// maps each byte to its run of one to four characters and queues it in a
// two-entry buffer. The back end sends one character per cycle from its
// output register while the receiver does not stall, so a byte yields one or
// two characters (four characters for a three-byte group) and a final byte up
// to four. A request's first character passes through the buffer entry and
// then the output register.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   logic                variant_ff;
   logic                fifo_full, fifo_empty, push, pop;
   b64e_pkg::entry_type push_data, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= b64e_pkg::VARIANT_URL;
      end else if (csr_wr_en) begin
         variant_ff <= csr_wr_data;
      end
   end

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .variant     (variant_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .fifo_full   (fifo_full),
      .push        (push),
      .push_data   (push_data)
   );

   b64e_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (fifo_empty)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_empty   (fifo_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ----- bench/base64_stream_encoder_test.sv -----
module base64_stream_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam string URL_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
   localparam string STD_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int QUIET_LIMIT   = 1000;
   localparam int PHASE_ITEMS   = 125;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } b64_char_type;

   // tracks the encoder's group position and leftover bits, and holds the
   // characters each accepted byte should produce
   class b64_char_tracker_type;
      logic                variant;
      b64e_pkg::phase_type grp;
      logic [3:0]          carry;
      b64_char_type        pending_chars[$];
      int                  errors;

      function new();
         variant = b64e_pkg::VARIANT_URL;
         grp = b64e_pkg::PHASE_FIRST;
         carry = 4'd0;
         errors = 0;
      endfunction

      function void set_variant(logic v);
         variant = v;
      endfunction

      function logic [7:0] to_char(logic [5:0] six);
         string tab;
         tab = (variant == b64e_pkg::VARIANT_STD) ? STD_ALPHABET : URL_ALPHABET;
         return tab[six];
      endfunction

      function void encode_byte(logic [7:0] b, logic l);
         logic [7:0]   run[$];
         b64_char_type item;
         case (grp)
            b64e_pkg::PHASE_SECOND: begin
               run.push_back(to_char({carry[1:0], b[7:4]}));
               carry = b[3:0];
               grp = b64e_pkg::PHASE_THIRD;
               if (l) begin
                  run.push_back(to_char({carry, 2'b00}));
                  if (variant == b64e_pkg::VARIANT_STD) run.push_back(b64e_pkg::PAD_CHAR);
               end
            end
            b64e_pkg::PHASE_THIRD: begin
               run.push_back(to_char({carry, b[7:6]}));
               run.push_back(to_char(b[5:0]));
               carry = 4'd0;
               grp = b64e_pkg::PHASE_FIRST;
            end
            default: begin
               run.push_back(to_char(b[7:2]));
               carry = {2'b00, b[1:0]};
               grp = b64e_pkg::PHASE_SECOND;
               if (l) begin
                  run.push_back(to_char({carry[1:0], 4'b0000}));
                  if (variant == b64e_pkg::VARIANT_STD) begin
                     run.push_back(b64e_pkg::PAD_CHAR);
                     run.push_back(b64e_pkg::PAD_CHAR);
                  end
               end
            end
         endcase
         for (int i = 0; i < run.size(); i++) begin
            item.ch = run[i];
            item.last = l && (i == run.size() - 1);
            pending_chars.push_back(item);
         end
         if (l) begin
            grp = b64e_pkg::PHASE_FIRST;
            carry = 4'd0;
         end
      endfunction

      function void match_char(logic [7:0] c, logic l);
         b64_char_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char %h last %0b",
                     $time, c, l);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (c !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, c);
            errors++;
         end
         if (l !== want.last) begin
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     $time, want.last, l);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_last;

   b64_char_tracker_type chars_sb = new();
   int burst_left = 0;
   int quiet_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;

   base64_stream_encoder dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver back-pressure: one of four modes, picked anew at random when its span runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= (stall_left[1:0] == 2'd0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) chars_sb.match_char(rsp_out_char, rsp_out_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("base64_stream_encoder_test NOT OK");
            $finish;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            3: gap = $urandom_range(7, 20);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      req_in_last = l;
      do @(posedge clock); while (req_stall);
      chars_sb.encode_byte(b, l);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      while (chars_sb.pending_chars.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_variant(input logic v);
      wait_for_results();
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      chars_sb.set_variant(v);
   endtask

   task automatic send_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one, two and three byte messages in both alphabets; the three byte
      // one hits the two characters that differ between them
      for (int v = 0; v < 2; v++) begin
         if (v == 1) write_variant(b64e_pkg::VARIANT_STD);
         send_byte(8'h00, 1'b1);
         send_byte(8'hFF, 1'b0);
         send_byte(8'hFF, 1'b1);
         send_byte(8'hFB, 1'b0);
         send_byte(8'hFF, 1'b0);
         send_byte(8'hBF, 1'b1);
      end
      // alphabet switched in the middle of a message
      send_byte(8'h4D, 1'b0);
      write_variant(b64e_pkg::VARIANT_URL);
      send_byte(8'hFB, 1'b1);
      send_byte(8'hFF, 1'b0);
      write_variant(b64e_pkg::VARIANT_STD);
      send_byte(8'hFE, 1'b1);
      // four bytes: last one opens a new group
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b1);

      for (int p = 0; p < 4; p++) begin
         if (p == 3) write_variant(1'($urandom_range(0, 1)));
         else write_variant((p % 2 == 0) ? b64e_pkg::VARIANT_URL : b64e_pkg::VARIANT_STD);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
            send_message(len);
            sent += len;
            // hold the sender off until the encoder has emptied
            if (p == 1 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2)
               wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (chars_sb.errors == 0 && chars_sb.pending_chars.size() == 0) begin
         $display("base64_stream_encoder_test OK");
      end else begin
         $display("base64_stream_encoder_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_fifo.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
bench/base64_stream_encoder_test.sv
